[design/pfe_pkg.sv]
`default_nettype none

package pfe_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int SYM_W       = 8;

  localparam int DIV_STEPS   = DATA_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [SYM_W-1:0] SYM_ADD  = 8'd43;
  localparam logic [SYM_W-1:0] SYM_SUB  = 8'd45;
  localparam logic [SYM_W-1:0] SYM_MUL  = 8'd42;
  localparam logic [SYM_W-1:0] SYM_DIV  = 8'd47;
  localparam logic [SYM_W-1:0] SYM_ZERO = 8'd48;

  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  // sticky error flag positions
  localparam int FLAG_UNDER = 0;
  localparam int FLAG_OVER  = 1;
  localparam int FLAG_DIVZ  = 2;
  localparam int FLAG_W     = 3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_B,
    S_POP_A,
    S_EXEC,
    S_DIV,
    S_FIN,
    S_FIN_RD
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic is_operator(input logic [SYM_W-1:0] sym);
    is_operator = (sym == SYM_ADD) || (sym == SYM_SUB) ||
                  (sym == SYM_MUL) || (sym == SYM_DIV);
  endfunction

endpackage

`default_nettype wire

[design/pfe_if.sv]
`default_nettype none

interface pfe_in_if;
  logic                        valid;
  logic                        ready;
  logic [pfe_pkg::SYM_W-1:0]   symbol;
  logic                        last_symbol;

  modport source (output valid, output symbol, output last_symbol, input ready);
  modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface pfe_out_if;
  logic                        valid;
  logic                        ready;
  logic signed [pfe_pkg::DATA_W-1:0] value;
  logic                        underflow_seen;
  logic                        overflow_seen;
  logic                        div_zero_seen;

  modport source (output valid, output value, output underflow_seen,
                  output overflow_seen, output div_zero_seen, input ready);
  modport sink   (input valid, input value, input underflow_seen,
                  input overflow_seen, input div_zero_seen, output ready);
endinterface

`default_nettype wire

[design/pfe_div.sv]
`default_nettype none

// Signed 32-bit divider, restoring, one quotient bit per cycle.
// Truncates toward zero; a zero divisor is handled by the caller.
module pfe_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire pfe_pkg::div_req_t req,
  output pfe_pkg::div_rsp_t      rsp
);

  logic                              busy_r;
  logic                              done_r;
  logic [pfe_pkg::DIV_CNT_W-1:0]     cnt_r;
  logic [pfe_pkg::DATA_W-1:0]        rem_r;
  logic [pfe_pkg::DATA_W-1:0]        quo_r;
  logic [pfe_pkg::DATA_W-1:0]        dvs_r;
  logic                              neg_r;

  logic [pfe_pkg::DATA_W:0]          rem_sh;
  logic [pfe_pkg::DATA_W:0]          diff;
  logic [pfe_pkg::DATA_W-1:0]        mag_a;
  logic [pfe_pkg::DATA_W-1:0]        mag_b;

  assign mag_a  = req.dividend[pfe_pkg::DATA_W-1] ? (~req.dividend + 1'b1) : req.dividend;
  assign mag_b  = req.divisor[pfe_pkg::DATA_W-1]  ? (~req.divisor + 1'b1)  : req.divisor;
  assign rem_sh = {rem_r, quo_r[pfe_pkg::DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pfe_pkg::DIV_CNT_W'(pfe_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= mag_a;
      dvs_r <= mag_b;
      neg_r <= req.dividend[pfe_pkg::DATA_W-1] ^ req.divisor[pfe_pkg::DATA_W-1];
    end else if (busy_r) begin
      if (!diff[pfe_pkg::DATA_W]) begin
        rem_r <= diff[pfe_pkg::DATA_W-1:0];
        quo_r <= {quo_r[pfe_pkg::DATA_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[pfe_pkg::DATA_W-1:0];
        quo_r <= {quo_r[pfe_pkg::DATA_W-2:0], 1'b0};
      end
    end
  end

  // most negative / -1 gives most negative: signs agree, no negate
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (~quo_r + 1'b1) : quo_r;

endmodule

`default_nettype wire

[design/postfix_expression_evaluator_top.sv]
// Channel   Dir  Handshake      Payload
// in_chan   in   valid/ready    symbol[7:0], last_symbol
// out_chan  out  valid/ready    value[31:0] signed, underflow_seen, overflow_seen,
//                               div_zero_seen
//
// Sequencing: a digit is pushed as it is accepted; +, - and * pop two operands through
// the registered read port, then execute and write back; / with a nonzero divisor
// waits for the divider, which retires one quotient bit per cycle. A last symbol
// adds a final pop. Reset: synchronous, active low; clears the stack count, flags,
// state and output valid. The stack memory is not cleared. Stalls: a result waits in
// the output register while new requests are taken; the final pop of the next
// expression waits until that register is free.
`default_nettype none

module postfix_expression_evaluator_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pfe_in_if.sink     in_chan,
  pfe_out_if.source  out_chan
);

  // ---------------------------------------------------------------------------
  // Stack memory: one write port, one registered read port
  // ---------------------------------------------------------------------------
  logic [pfe_pkg::DATA_W-1:0] stack_mem [pfe_pkg::STACK_DEPTH];
  logic [pfe_pkg::DATA_W-1:0] rd_data_r;
  logic                       rd_en;
  logic [pfe_pkg::ADDR_W-1:0] rd_addr;
  logic                       wr_en;
  logic [pfe_pkg::ADDR_W-1:0] wr_addr;

  // ---------------------------------------------------------------------------
  // Control state
  // ---------------------------------------------------------------------------
  pfe_pkg::state_t             state_r, state_nxt;
  logic [pfe_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [pfe_pkg::FLAG_W-1:0]  flags_r, flags_nxt, flags_upd;
  logic                        pop_empty_r;

  // latched request
  logic [pfe_pkg::SYM_W-1:0]   sym_r;
  logic                        last_r;

  // operands and output register
  logic [pfe_pkg::DATA_W-1:0]  a_r, b_r;
  logic                        out_valid_r;
  logic [pfe_pkg::DATA_W-1:0]  out_value_r;
  logic [pfe_pkg::FLAG_W-1:0]  out_flags_r;

  // per-cycle controls
  logic                        in_acc;
  logic                        in_is_op;
  logic                        out_free;
  logic                        stack_empty;
  logic                        stack_full;
  logic                        pop_req;
  logic                        push_req;
  logic [pfe_pkg::DATA_W-1:0]  push_val;
  logic                        divz_set;
  logic                        fin_load;
  logic [pfe_pkg::DATA_W-1:0]  fin_value;
  logic [pfe_pkg::DATA_W-1:0]  alu_res;
  logic [pfe_pkg::DATA_W-1:0]  digit_val;
  logic                        b_zero;

  pfe_pkg::div_req_t           div_req;
  pfe_pkg::div_rsp_t           div_rsp;

  assign in_acc      = in_chan.valid && in_chan.ready;
  assign in_is_op    = pfe_pkg::is_operator(in_chan.symbol);
  assign out_free    = !out_valid_r || out_chan.ready;
  assign stack_empty = (cnt_r == '0);
  assign stack_full  = (cnt_r == pfe_pkg::CNT_W'(pfe_pkg::STACK_DEPTH));
  assign b_zero      = (b_r == '0);
  assign digit_val   = {{(pfe_pkg::DATA_W - pfe_pkg::SYM_W){1'b0}}, in_chan.symbol}
                       - {{(pfe_pkg::DATA_W - pfe_pkg::SYM_W){1'b0}}, pfe_pkg::SYM_ZERO};

  // add / sub / mul: low 32 bits wrap
  always_comb begin
    unique case (sym_r)
      pfe_pkg::SYM_ADD: alu_res = a_r + b_r;
      pfe_pkg::SYM_SUB: alu_res = a_r - b_r;
      default:          alu_res = a_r * b_r;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfe_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_is_op) begin
            state_nxt = pfe_pkg::S_POP_B;
          end else if (in_chan.last_symbol) begin
            state_nxt = pfe_pkg::S_FIN;
          end
        end
      end
      pfe_pkg::S_POP_B: state_nxt = pfe_pkg::S_POP_A;
      pfe_pkg::S_POP_A: state_nxt = pfe_pkg::S_EXEC;
      pfe_pkg::S_EXEC: begin
        if ((sym_r == pfe_pkg::SYM_DIV) && !b_zero) begin
          state_nxt = pfe_pkg::S_DIV;
        end else begin
          state_nxt = last_r ? pfe_pkg::S_FIN : pfe_pkg::S_IDLE;
        end
      end
      pfe_pkg::S_DIV: begin
        if (div_rsp.done) begin
          state_nxt = last_r ? pfe_pkg::S_FIN : pfe_pkg::S_IDLE;
        end
      end
      pfe_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = stack_empty ? pfe_pkg::S_IDLE : pfe_pkg::S_FIN_RD;
        end
      end
      pfe_pkg::S_FIN_RD: state_nxt = pfe_pkg::S_IDLE;
      default: state_nxt = pfe_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Outputs of the sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    in_chan.ready    = 1'b0;
    pop_req          = 1'b0;
    push_req         = 1'b0;
    push_val         = alu_res;
    divz_set         = 1'b0;
    fin_load         = 1'b0;
    fin_value        = rd_data_r;
    div_req.start    = 1'b0;
    div_req.dividend = a_r;
    div_req.divisor  = b_r;
    unique case (state_r)
      pfe_pkg::S_IDLE: begin
        in_chan.ready = 1'b1;
        // ready is high here, so valid alone marks the accepted request
        if (in_chan.valid) begin
          if (in_is_op) begin
            pop_req = 1'b1;          // right operand
          end else begin
            push_req = 1'b1;
            push_val = digit_val;
          end
        end
      end
      pfe_pkg::S_POP_B: pop_req = 1'b1;  // left operand
      pfe_pkg::S_POP_A: ;
      pfe_pkg::S_EXEC: begin
        if (sym_r == pfe_pkg::SYM_DIV) begin
          if (b_zero) begin
            push_req = 1'b1;
            push_val = '0;
            divz_set = 1'b1;
          end else begin
            div_req.start = 1'b1;
          end
        end else begin
          push_req = 1'b1;
        end
      end
      pfe_pkg::S_DIV: begin
        push_req = div_rsp.done;
        push_val = div_rsp.quotient;
      end
      pfe_pkg::S_FIN: begin
        if (out_free) begin
          pop_req   = 1'b1;
          fin_load  = stack_empty;   // empty: emit -1 straight away
          fin_value = pfe_pkg::EMPTY_VALUE;
        end
      end
      pfe_pkg::S_FIN_RD: fin_load = 1'b1;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stack pointer, flags and memory ports
  // ---------------------------------------------------------------------------
  assign rd_en   = pop_req && !stack_empty;
  assign rd_addr = pfe_pkg::ADDR_W'(cnt_r - 1'b1);
  assign wr_en   = push_req && !stack_full;
  assign wr_addr = cnt_r[pfe_pkg::ADDR_W-1:0];

  always_comb begin
    flags_upd = flags_r;
    if (pop_req && stack_empty) flags_upd[pfe_pkg::FLAG_UNDER] = 1'b1;
    if (push_req && stack_full) flags_upd[pfe_pkg::FLAG_OVER]  = 1'b1;
    if (divz_set)               flags_upd[pfe_pkg::FLAG_DIVZ]  = 1'b1;
    flags_nxt = fin_load ? '0 : flags_upd;

    cnt_nxt = cnt_r;
    if (fin_load) begin
      cnt_nxt = '0;                 // expression done: empty the stack
    end else if (rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end else if (wr_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stack_mem[wr_addr] <= push_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= stack_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfe_pkg::S_IDLE;
      cnt_r       <= '0;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      flags_r <= flags_nxt;
      if (fin_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop_req) begin
      pop_empty_r <= stack_empty;
    end
    if (in_acc) begin
      sym_r  <= in_chan.symbol;
      last_r <= in_chan.last_symbol;
    end
    // an empty pop reads as -1
    if (state_r == pfe_pkg::S_POP_B) begin
      b_r <= pop_empty_r ? pfe_pkg::EMPTY_VALUE : rd_data_r;
    end
    if (state_r == pfe_pkg::S_POP_A) begin
      a_r <= pop_empty_r ? pfe_pkg::EMPTY_VALUE : rd_data_r;
    end
    if (fin_load) begin
      out_value_r <= fin_value;
      out_flags_r <= flags_upd;
    end
  end

  pfe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_chan.valid          = out_valid_r;
  assign out_chan.value          = out_value_r;
  assign out_chan.underflow_seen = out_flags_r[pfe_pkg::FLAG_UNDER];
  assign out_chan.overflow_seen  = out_flags_r[pfe_pkg::FLAG_OVER];
  assign out_chan.div_zero_seen  = out_flags_r[pfe_pkg::FLAG_DIVZ];

endmodule

`default_nettype wire

[design/pfe_chk.sv]
`default_nettype none

module pfe_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic [pfe_pkg::SYM_W-1:0]   in_symbol,
  input wire logic                        in_last,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [pfe_pkg::DATA_W-1:0]  out_value
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // expressions closed but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_acc && in_last} - {1'b0, out_acc};
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result without a closing symbol");

  a_op_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && pfe_pkg::is_operator(in_symbol)) |=> !in_ready)
    else $error("operator request did not stall the input");

  a_digit_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_last && !pfe_pkg::is_operator(in_symbol)) |=> in_ready)
    else $error("digit push held the input");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_value)))
    else $error("stalled result changed");

endmodule

bind postfix_expression_evaluator_top pfe_chk u_pfe_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_symbol (in_chan.symbol),
  .in_last   (in_chan.last_symbol),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_value (out_chan.value)
);

`default_nettype wire

[dv/tb_postfix_expression_evaluator_top.sv]
`default_nettype none

module tb_postfix_expression_evaluator_top;
  timeunit 1ns;
  timeprecision 1ps;

  // ---------------------------------------------------------------------------
  // Run sizing
  // ---------------------------------------------------------------------------
  localparam int ITEM_TARGET  = 900;   // stop issuing new expressions past this
  localparam int STALL_LIMIT  = 4000;  // cycles with no request moving on either side
  localparam int HOLD_CYCLES  = 400;   // long receiver hold-off for the back-pressure phase
  localparam int DRAIN_CYCLES = 80;    // divide plus final pop, with margin

  // One expected result of a whole expression
  typedef struct packed {
    logic [pfe_pkg::DATA_W-1:0] value;
    logic                       underflow;
    logic                       overflow;
    logic                       div_zero;
  } rpn_result_t;

  // ---------------------------------------------------------------------------
  // Scoreboard: a private copy of the operand stack and the sticky flags,
  // stepped once per accepted symbol; each last symbol queues one result.
  // ---------------------------------------------------------------------------
  class rpn_scoreboard;
    logic [pfe_pkg::DATA_W-1:0] operands [pfe_pkg::STACK_DEPTH];
    int unsigned                depth          = 0;
    logic [pfe_pkg::FLAG_W-1:0] sticky_flags   = '0;
    rpn_result_t                results_due[$];
    int                         mismatches     = 0;
    int                         symbols_seen   = 0;
    int                         results_done   = 0;
    int                         underflow_runs = 0;
    int                         overflow_runs  = 0;
    int                         div_zero_runs  = 0;

    function logic [pfe_pkg::DATA_W-1:0] pop_operand();
      if (depth == 0) begin
        sticky_flags[pfe_pkg::FLAG_UNDER] = 1'b1;
        return '1;
      end
      depth--;
      return operands[depth];
    endfunction

    function void push_operand(input logic [pfe_pkg::DATA_W-1:0] v);
      if (depth >= pfe_pkg::STACK_DEPTH) begin
        sticky_flags[pfe_pkg::FLAG_OVER] = 1'b1;
        return;
      end
      operands[depth] = v;
      depth++;
    endfunction

    // Signed divide done in 64 bits so that the most negative value over
    // minus one wraps rather than trapping.
    function logic [pfe_pkg::DATA_W-1:0] divide_trunc(
        input logic [pfe_pkg::DATA_W-1:0] a, input logic [pfe_pkg::DATA_W-1:0] b);
      longint      dividend;
      longint      divisor;
      logic [63:0] quot64;
      if (b == '0) begin
        sticky_flags[pfe_pkg::FLAG_DIVZ] = 1'b1;
        return '0;
      end
      dividend = longint'($signed(a));
      divisor  = longint'($signed(b));
      quot64   = dividend / divisor;
      return quot64[pfe_pkg::DATA_W-1:0];
    endfunction

    function void note_symbol(input logic [pfe_pkg::SYM_W-1:0] sym, input logic last);
      logic [pfe_pkg::DATA_W-1:0] a;
      logic [pfe_pkg::DATA_W-1:0] b;
      logic [pfe_pkg::DATA_W-1:0] r;
      rpn_result_t                res;
      symbols_seen++;
      if (sym inside {pfe_pkg::SYM_ADD, pfe_pkg::SYM_SUB, pfe_pkg::SYM_MUL,
                      pfe_pkg::SYM_DIV}) begin
        b = pop_operand();
        a = pop_operand();
        case (sym)
          pfe_pkg::SYM_ADD: r = a + b;
          pfe_pkg::SYM_SUB: r = a - b;
          pfe_pkg::SYM_MUL: r = a * b;
          default:          r = divide_trunc(a, b);
        endcase
        push_operand(r);
      end else begin
        push_operand({{(pfe_pkg::DATA_W-pfe_pkg::SYM_W){1'b0}}, sym}
                     - pfe_pkg::DATA_W'(pfe_pkg::SYM_ZERO));
      end
      if (!last) return;
      res.value     = pop_operand();
      res.underflow = sticky_flags[pfe_pkg::FLAG_UNDER];
      res.overflow  = sticky_flags[pfe_pkg::FLAG_OVER];
      res.div_zero  = sticky_flags[pfe_pkg::FLAG_DIVZ];
      underflow_runs += res.underflow;
      overflow_runs  += res.overflow;
      div_zero_runs  += res.div_zero;
      results_due    = {results_due, res};
      depth        = 0;
      sticky_flags = '0;
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task check_result(input logic [pfe_pkg::DATA_W-1:0] value, input logic underflow,
                      input logic overflow, input logic div_zero);
      rpn_result_t want;
      if (results_due.size() == 0) begin
        report_mismatch($sformatf("result value=%0d with no expression pending",
                                  $signed(value)));
        return;
      end
      want = results_due.pop_front();
      results_done++;
      if (value !== want.value)
        report_mismatch($sformatf("value got %0d want %0d", $signed(value),
                                  $signed(want.value)));
      if (underflow !== want.underflow)
        report_mismatch($sformatf("underflow_seen got %b want %b", underflow,
                                  want.underflow));
      if (overflow !== want.overflow)
        report_mismatch($sformatf("overflow_seen got %b want %b", overflow,
                                  want.overflow));
      if (div_zero !== want.div_zero)
        report_mismatch($sformatf("div_zero_seen got %b want %b", div_zero,
                                  want.div_zero));
    endtask

    function int pending_count();
      return results_due.size();
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, channels, block under test
  // ---------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  pfe_in_if  in_chan();
  pfe_out_if out_chan();

  postfix_expression_evaluator_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  rpn_scoreboard sb;

  int send_idle_pct = 12;   // chance per request that the sender idles first
  int recv_idle_pct = 12;   // chance per cycle that the receiver drops ready
  bit hold_request  = 1'b0; // asks the receiver process for one long hold-off
  int sent_items    = 0;
  int quiet_cycles  = 0;    // watchdog: cycles since the last request moved

  initial sb = new;

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Results are checked
  // before the symbol of the same edge is noted, so a result can never be
  // matched against an expression that only closes on that edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready)
        sb.check_result(out_chan.value, out_chan.underflow_seen,
                        out_chan.overflow_seen, out_chan.div_zero_seen);
      if (in_chan.valid && in_chan.ready)
        sb.note_symbol(in_chan.symbol, in_chan.last_symbol);
    end
  end

  // Watchdog: only counts stretches in which nothing at all is accepted
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: %0d cycles with no request accepted", STALL_LIMIT);
      $display("tb_postfix_expression_evaluator_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random ready at the falling edge, plus one long hold-off that
  // it counts itself when asked, so the block backs up into its input.
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    hold_left      = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_chan.ready = 1'b0;
        hold_left--;
      end else begin
        out_chan.ready = ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender tasks
  // ---------------------------------------------------------------------------

  // Offer one symbol from a falling edge and hold it until taken; returns on
  // the falling edge after acceptance with valid still high.
  task automatic send_symbol(input logic [pfe_pkg::SYM_W-1:0] sym, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid = 1'b0;
      @(negedge clk);
    end
    in_chan.valid       = 1'b1;
    in_chan.symbol      = sym;
    in_chan.last_symbol = last;
    do @(posedge clk); while (!in_chan.ready);
    sent_items++;
    @(negedge clk);
  endtask

  // Fixed sequence; the final symbol closes the expression
  task automatic send_sequence(input logic [pfe_pkg::SYM_W-1:0] syms[$]);
    foreach (syms[i])
      send_symbol(syms[i], i == syms.size() - 1);
  endtask

  // Mostly decimal digits, sometimes any byte that is not an operator
  function automatic logic [pfe_pkg::SYM_W-1:0] pick_operand();
    logic [pfe_pkg::SYM_W-1:0] sym;
    if ($urandom_range(0, 99) < 75)
      return pfe_pkg::SYM_ZERO + pfe_pkg::SYM_W'($urandom_range(0, 9));
    do sym = pfe_pkg::SYM_W'($urandom_range(0, 255));
    while (sym inside {pfe_pkg::SYM_ADD, pfe_pkg::SYM_SUB, pfe_pkg::SYM_MUL,
                       pfe_pkg::SYM_DIV});
    return sym;
  endfunction

  function automatic logic [pfe_pkg::SYM_W-1:0] pick_operator();
    case ($urandom_range(0, 3))
      0:       return pfe_pkg::SYM_ADD;
      1:       return pfe_pkg::SYM_SUB;
      2:       return pfe_pkg::SYM_MUL;
      default: return pfe_pkg::SYM_DIV;
    endcase
  endfunction

  // Well-formed postfix with the given operand count: an operator only ever
  // lands when two operands are available, and it ends with one left.
  // Past the stack depth the tracking is nominal, which is what drives the
  // overflow and then underflow paths on deep expressions.
  task automatic send_expression(input int n_operands);
    int                        depth;
    int                        left;
    logic [pfe_pkg::SYM_W-1:0] sym;
    depth = 0;
    left  = n_operands;
    while (left > 0 || depth > 1) begin
      if (left > 0 && (depth < 2 || $urandom_range(0, 1))) begin
        sym = pick_operand();
        left--;
        depth++;
      end else begin
        sym = pick_operator();
        depth--;
      end
      send_symbol(sym, left == 0 && depth == 1);
    end
  endtask

  // Short run of arbitrary symbols, operators placed anywhere
  task automatic send_noise();
    int                        len;
    logic [pfe_pkg::SYM_W-1:0] sym;
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 35) sym = pick_operator();
      else                            sym = pfe_pkg::SYM_W'($urandom_range(0, 255));
      send_symbol(sym, i == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int roll;

    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.symbol      = '0;
    in_chan.last_symbol = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: one expression per operation, underflow and divide by zero
    send_sequence('{pfe_pkg::SYM_ZERO + 8'd3, pfe_pkg::SYM_ZERO + 8'd4,
                    pfe_pkg::SYM_ADD});                             // 7
    send_sequence('{pfe_pkg::SYM_SUB});                             // both pops empty
    send_sequence('{pfe_pkg::SYM_ZERO + 8'd7, pfe_pkg::SYM_ZERO,
                    pfe_pkg::SYM_DIV});                             // zero divisor
    send_sequence('{8'd0, 8'd255, pfe_pkg::SYM_MUL});               // -48 * 207
    send_sequence('{8'd0, pfe_pkg::SYM_ZERO + 8'd5,
                    pfe_pkg::SYM_DIV});                             // -48/5 truncates to -9
    // 128^4 * 8 wraps to the most negative value, then divide by (0 - 1)
    send_sequence('{8'd176, 8'd176, pfe_pkg::SYM_MUL, 8'd176, pfe_pkg::SYM_MUL,
                    8'd176, pfe_pkg::SYM_MUL, pfe_pkg::SYM_ZERO + 8'd8,
                    pfe_pkg::SYM_MUL, pfe_pkg::SYM_ZERO, pfe_pkg::SYM_ZERO + 8'd1,
                    pfe_pkg::SYM_SUB, pfe_pkg::SYM_DIV});

    // Back-pressure: receiver holds off while the sender keeps offering
    // complete expressions with no gaps, so a finished result waits in the
    // output register and the input stalls behind it.
    send_idle_pct = 0;
    hold_request  = 1'b1;
    repeat (12) send_expression($urandom_range(2, 4));
    send_idle_pct = 12;

    // One expression with more operands than the stack is deep
    send_expression($urandom_range(pfe_pkg::STACK_DEPTH + 2, pfe_pkg::STACK_DEPTH + 8));

    // Random mix; a stretch in the middle runs with no idling on either side
    while (sent_items < ITEM_TARGET) begin
      if (sent_items > 450 && sent_items < 600) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 12;
        recv_idle_pct = 12;
      end
      roll = $urandom_range(0, 99);
      if (roll < 86)      send_expression($urandom_range(1, 8));
      else if (roll < 87) send_expression($urandom_range(pfe_pkg::STACK_DEPTH - 2,
                                                         pfe_pkg::STACK_DEPTH + 8));
      else                send_noise();
    end
    in_chan.valid = 1'b0;

    // Drain; the watchdog bounds this wait
    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d symbols in %0d checked expressions", sb.symbols_seen,
             sb.results_done);
    $display("expressions with underflow %0d, overflow %0d, divide by zero %0d",
             sb.underflow_runs, sb.overflow_runs, sb.div_zero_runs);
    if (sb.mismatches == 0 && sb.pending_count() == 0)
      $display("tb_postfix_expression_evaluator_top: PASS");
    else
      $display("tb_postfix_expression_evaluator_top: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
